FILE: hdl/assert_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PDC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define PDC_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define PDC_ASSERT(label, clk, rst, prop)
`define PDC_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: hdl/pdc_pkg.sv
// Types, codes and helpers shared by the packet deframer modules.
package pdc_pkg;

   localparam int HEADER_BYTES = 8;
   localparam logic [2:0] HEADER_LAST = 3'(HEADER_BYTES - 3);

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_LEN_TOO_BIG  = 3'd1;
   localparam logic [2:0] ST_LEN_CHECK    = 3'd2;
   localparam logic [2:0] ST_SUM_BAD      = 3'd3;
   localparam logic [2:0] ST_HEAD_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_DATA_TIMEOUT = 3'd5;

   typedef enum logic [1:0] {
      CSR_START_HIGH   = 2'd0,
      CSR_START_LOW    = 2'd1,
      CSR_MAX_LENGTH   = 2'd2,
      CSR_BYTE_TIMEOUT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_MARK = 2'd1,
      PH_HEAD = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [15:0] frame_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  start_high;
      logic [7:0]  start_low;
      logic [15:0] max_length;
      logic [15:0] byte_timeout;
   } cfg_type;

   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type item0;
      rsp_type item1;
   } push_type;

   function automatic rsp_type make_byte(input logic [7:0] value);
      rsp_type r;
      r.kind         = KIND_BYTE;
      r.payload_byte = value;
      r.status       = ST_OK;
      r.frame_length = 16'h0000;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic rsp_type make_status(input logic [2:0] code, input logic [15:0] len);
      rsp_type r;
      r.kind         = KIND_STATUS;
      r.payload_byte = 8'h00;
      r.status       = code;
      r.frame_length = len;
      r.last         = 1'b1;
      return r;
   endfunction

endpackage

FILE: hdl/packet_deframer_checksum.sv
// Top level of the framed packet receiver with 16-bit payload checksum.
// Takes one request per cycle (a received byte or a timer tick) and
// finishes it in that same cycle; results go through a four-entry queue,
// so a request is taken whenever at least two queue entries are free. The
// last payload byte of a frame gives two results (the byte, then the
// closing status), every other request gives at most one, so a reader
// that always takes results never stalls the input. Write configuration
// only while no frame is open.
module packet_deframer_checksum (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pdc_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pdc_pkg::rsp_type  rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   pdc_pkg::cfg_type  cfg;
   pdc_pkg::push_type push;
   logic              has_room;

   assign req_ready = has_room;

   pdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pdc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (req_valid && req_ready),
      .req    (req_payload),
      .cfg    (cfg),
      .push   (push)
   );

   pdc_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .has_room    (has_room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hdl/pdc_csr.sv
// Configuration registers of the packet deframer.
module pdc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   output pdc_pkg::cfg_type       cfg
);

   pdc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (pdc_pkg::csr_index_type'(csr_index))
            pdc_pkg::CSR_START_HIGH:   cfg_in.start_high   = csr_wdata[7:0];
            pdc_pkg::CSR_START_LOW:    cfg_in.start_low    = csr_wdata[7:0];
            pdc_pkg::CSR_MAX_LENGTH:   cfg_in.max_length   = csr_wdata;
            pdc_pkg::CSR_BYTE_TIMEOUT: cfg_in.byte_timeout = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_high   <= 8'hAA;
         cfg_ff.start_low    <= 8'h55;
         cfg_ff.max_length   <= 16'd1024;
         cfg_ff.byte_timeout <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/pdc_core.sv
// Frame state machine, header checks and payload checksum.
`include "assert_macros.svh"
module pdc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  pdc_pkg::req_type   req,
   input  pdc_pkg::cfg_type   cfg,
   output pdc_pkg::push_type  push
);

   pdc_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] payload_length_ff, payload_length_in;
   logic [7:0]  length_check_ff, length_check_in;
   logic [15:0] received_sum_ff, received_sum_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  pending_high_ff, pending_high_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;

   logic [16:0] tick_next;
   logic        odd_pos;
   logic        is_last;
   logic [15:0] seen_next;
   logic [15:0] add;
   logic [16:0] sum_wide;
   logic [15:0] folded;

   always_comb begin
      tick_next = {1'b0, idle_ticks_ff} + 17'd1;
      odd_pos   = bytes_seen_ff[0];
      seen_next = bytes_seen_ff + 16'd1;
      is_last   = (seen_next == payload_length_ff);
      if (odd_pos) begin
         add = {pending_high_ff, req.rx_byte};
      end else if (is_last) begin
         add = {8'h00, req.rx_byte};
      end else begin
         add = 16'h0000;
      end
      sum_wide = {1'b0, running_sum_ff} + {1'b0, add};
      folded   = sum_wide[15:0] + {15'd0, sum_wide[16]};
   end

   always_comb begin
      phase_in          = phase_ff;
      pos_in            = pos_ff;
      length_high_in    = length_high_ff;
      payload_length_in = payload_length_ff;
      length_check_in   = length_check_ff;
      received_sum_in   = received_sum_ff;
      bytes_seen_in     = bytes_seen_ff;
      running_sum_in    = running_sum_ff;
      pending_high_in   = pending_high_ff;
      idle_ticks_in     = idle_ticks_ff;
      push.push0        = 1'b0;
      push.push1        = 1'b0;
      push.item0        = pdc_pkg::make_byte(req.rx_byte);
      push.item1        = pdc_pkg::make_status(pdc_pkg::ST_OK, payload_length_ff);

      if (accept) begin
         if (req.op == pdc_pkg::OP_TICK) begin
            if (phase_ff == pdc_pkg::PH_HEAD || phase_ff == pdc_pkg::PH_DATA) begin
               if (tick_next > {1'b0, cfg.byte_timeout}) begin
                  push.push0    = 1'b1;
                  push.item0    = (phase_ff == pdc_pkg::PH_HEAD)
                     ? pdc_pkg::make_status(pdc_pkg::ST_HEAD_TIMEOUT, 16'h0000)
                     : pdc_pkg::make_status(pdc_pkg::ST_DATA_TIMEOUT, payload_length_ff);
                  phase_in      = pdc_pkg::PH_HUNT;
                  pos_in        = 3'd0;
                  idle_ticks_in = 16'h0000;
               end else begin
                  idle_ticks_in = tick_next[15:0];
               end
            end
         end else begin
            unique case (phase_ff)
               pdc_pkg::PH_HUNT: begin
                  if (req.rx_byte == cfg.start_high) begin
                     phase_in = pdc_pkg::PH_MARK;
                  end
               end
               pdc_pkg::PH_MARK: begin
                  if (req.rx_byte == cfg.start_low) begin
                     phase_in      = pdc_pkg::PH_HEAD;
                     pos_in        = 3'd0;
                     idle_ticks_in = 16'h0000;
                  end else begin
                     phase_in = pdc_pkg::PH_HUNT;
                  end
               end
               pdc_pkg::PH_HEAD: begin
                  idle_ticks_in = 16'h0000;
                  case (pos_ff)
                     3'd0:    length_high_in    = req.rx_byte;
                     3'd1:    payload_length_in = {length_high_ff, req.rx_byte};
                     3'd2:    ;
                     3'd3:    length_check_in   = req.rx_byte;
                     3'd4:    received_sum_in   = {req.rx_byte, 8'h00};
                     default: received_sum_in   = {received_sum_ff[15:8], req.rx_byte};
                  endcase
                  if (pos_ff < pdc_pkg::HEADER_LAST) begin
                     pos_in = pos_ff + 3'd1;
                  end else begin
                     pos_in = 3'd0;
                     if (payload_length_ff > cfg.max_length) begin
                        push.push0 = 1'b1;
                        push.item0 = pdc_pkg::make_status(pdc_pkg::ST_LEN_TOO_BIG,
                                                          payload_length_ff);
                        phase_in   = pdc_pkg::PH_HUNT;
                     end else if (length_check_ff !=
                                  (length_high_ff ^ payload_length_ff[7:0])) begin
                        push.push0 = 1'b1;
                        push.item0 = pdc_pkg::make_status(pdc_pkg::ST_LEN_CHECK,
                                                          payload_length_ff);
                        phase_in   = pdc_pkg::PH_HUNT;
                     end else if (payload_length_ff == 16'h0000) begin
                        push.push0 = 1'b1;
                        push.item0 = pdc_pkg::make_status(
                           (received_sum_in == 16'h0000) ? pdc_pkg::ST_OK
                                                         : pdc_pkg::ST_SUM_BAD,
                           16'h0000);
                        phase_in   = pdc_pkg::PH_HUNT;
                     end else begin
                        phase_in        = pdc_pkg::PH_DATA;
                        bytes_seen_in   = 16'h0000;
                        running_sum_in  = 16'h0000;
                        pending_high_in = 8'h00;
                     end
                  end
               end
               pdc_pkg::PH_DATA: begin
                  idle_ticks_in  = 16'h0000;
                  push.push0     = 1'b1;
                  push.item0     = pdc_pkg::make_byte(req.rx_byte);
                  bytes_seen_in  = seen_next;
                  running_sum_in = folded;
                  if (!odd_pos) begin
                     pending_high_in = req.rx_byte;
                  end
                  if (is_last) begin
                     push.push1 = 1'b1;
                     push.item1 = pdc_pkg::make_status(
                        (~folded == received_sum_ff) ? pdc_pkg::ST_OK
                                                     : pdc_pkg::ST_SUM_BAD,
                        payload_length_ff);
                     phase_in   = pdc_pkg::PH_HUNT;
                     pos_in     = 3'd0;
                  end
               end
               default: phase_in = pdc_pkg::PH_HUNT;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= pdc_pkg::PH_HUNT;
         pos_ff            <= 3'd0;
         length_high_ff    <= 8'h00;
         payload_length_ff <= 16'h0000;
         length_check_ff   <= 8'h00;
         received_sum_ff   <= 16'h0000;
         bytes_seen_ff     <= 16'h0000;
         running_sum_ff    <= 16'h0000;
         pending_high_ff   <= 8'h00;
         idle_ticks_ff     <= 16'h0000;
      end else begin
         phase_ff          <= phase_in;
         pos_ff            <= pos_in;
         length_high_ff    <= length_high_in;
         payload_length_ff <= payload_length_in;
         length_check_ff   <= length_check_in;
         received_sum_ff   <= received_sum_in;
         bytes_seen_ff     <= bytes_seen_in;
         running_sum_ff    <= running_sum_in;
         pending_high_ff   <= pending_high_in;
         idle_ticks_ff     <= idle_ticks_in;
      end
   end

   `PDC_NEVER(a_second_alone, clock, reset, push.push1 && !push.push0)
   `PDC_NEVER(a_data_len_zero, clock, reset,
              phase_ff == pdc_pkg::PH_DATA && payload_length_ff == 16'h0000)
   `PDC_NEVER(a_pos_range, clock, reset, pos_ff > pdc_pkg::HEADER_LAST)
   `PDC_ASSERT(a_pair_ends_frame, clock, reset,
               push.push1 |-> (push.item0.kind == pdc_pkg::KIND_BYTE &&
                               push.item1.last && phase_in == pdc_pkg::PH_HUNT))

endmodule

FILE: hdl/pdc_out_queue.sv
// Four-entry result queue taking up to two results per cycle.
`include "assert_macros.svh"
module pdc_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  pdc_pkg::push_type  push,
   output logic               has_room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pdc_pkg::rsp_type   rsp_payload
);

   pdc_pkg::rsp_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] n_push;

   assign has_room    = (count_ff <= 3'd2);
   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;

   always_comb begin
      n_push    = {1'b0, push.push0} + {1'b0, push.push1};
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PDC_NEVER(a_count_range, clock, reset, count_ff > 3'd4)
   `PDC_NEVER(a_push_no_room, clock, reset, push.push0 && !has_room)
   `PDC_NEVER(a_ptr_gap, clock, reset,
              count_ff != 3'd4 && (wr_ptr_ff - rd_ptr_ff) != count_ff[1:0])

endmodule
